// ----- hdl/ssf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_pkg: shared types and helpers for the searchable shift FIFO
// Record layout, request and response words, cell control, name cleanup.
// ----------------------------------------------------------------------------
package ssf_pkg;

    localparam int DEPTH     = 8;
    localparam int POS_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int NAME_BYTES = 30;

    localparam logic [1:0] FUNC_PUSH   = 2'd0;
    localparam logic [1:0] FUNC_POP    = 2'd1;
    localparam logic [1:0] FUNC_SEARCH = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] name_word0;
        logic [63:0] name_word1;
        logic [63:0] name_word2;
        logic [47:0] name_word3;
        logic [7:0]  age;
    } t_req;

    typedef struct packed {
        logic             ok;
        logic             found;
        logic [2:0]       position;
        logic [63:0]      out_word0;
        logic [63:0]      out_word1;
        logic [63:0]      out_word2;
        logic [47:0]      out_word3;
        logic [7:0]       out_age;
        logic [3:0]       count;
        logic             empty_res;
        logic             full_res;
    } t_rsp;

    // one stored record: cleaned-up name plus age
    typedef struct packed {
        logic [47:0] w3;
        logic [63:0] w2;
        logic [63:0] w1;
        logic [63:0] w0;
        logic [7:0]  age;
    } t_rec;

    typedef struct packed {
        logic load_new;  // take the incoming record
        logic shift;     // take the neighbor's record
        logic cmp;       // latch compare result
    } t_cell_ctrl;

    // Zero every byte after the first zero byte, so names compare as strings.
    function automatic t_rec make_rec(input t_req req);
        logic [8*NAME_BYTES-1:0] flat;
        logic                    ended;
        t_rec                    rec;
        flat  = {req.name_word3, req.name_word2, req.name_word1, req.name_word0};
        ended = 1'b0;
        for (int k = 0; k < NAME_BYTES; k++) begin
            if (flat[8*k +: 8] == 8'd0) begin
                ended = 1'b1;
            end
            if (ended) begin
                flat[8*k +: 8] = 8'd0;
            end
        end
        rec.w0  = flat[63:0];
        rec.w1  = flat[127:64];
        rec.w2  = flat[191:128];
        rec.w3  = flat[239:192];
        rec.age = req.age;
        return rec;
    endfunction

endpackage

// ----- hdl/ssf_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_cell: one queue slot
// Holds a record, loads the new word or its neighbor's record, and latches
// whether its record matches the search key.
// ----------------------------------------------------------------------------
module ssf_cell
    import ssf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_rec       i_new_rec,
    input  t_rec       i_next_rec,
    input  t_rec       i_key,
    output t_rec       o_rec,
    output logic       o_match
);

    t_rec r_rec;
    logic r_match;

    // record payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_rec <= i_next_rec;
        end else if (i_ctrl.load_new) begin
            r_rec <= i_new_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctrl.cmp) begin
            r_match <= (r_rec == i_key);
        end
    end

    assign o_rec   = r_rec;
    assign o_match = r_match;

endmodule

// ----- hdl/ssf_first_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_first_match: priority pick of the lowest matching occupied cell
// ----------------------------------------------------------------------------
module ssf_first_match
    import ssf_pkg::*;
(
    input  logic [DEPTH-1:0] i_match,
    input  logic [CNT_W-1:0] i_count,
    output logic             o_found,
    output logic [POS_W-1:0] o_pos
);

    logic [DEPTH-1:0] hits;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            hits[i] = i_match[i] && (CNT_W'(i) < i_count);
        end
    end

    // scan from the tail so the head-most hit wins
    always_comb begin
        o_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (hits[i]) begin
                o_pos = POS_W'(i);
            end
        end
    end

    assign o_found = |hits;

endmodule

// ----- hdl/searchable_shift_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// searchable_shift_fifo: record queue in a row of register cells
// Push at tail, pop from head with a one-place shift, search by name and age.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a request word on i_req; it is taken when busy is low.
//   The response word shows on o_rsp for one cycle with o_done high; the
//   receiver cannot hold it off. Every request gives exactly one response.
//   An accepted request passes ST_EXEC, then ST_RESP, which registers the
//   response and raises o_done. The cycle after the accept the cells shift
//   or load and each latches its compare against the key; the next cycle
//   picks the first hit, and a new request may be taken then.
//   i_cfg_we / i_cfg_data write capacity (reset 8, clamps to the cell count,
//   zero means always full); write it only while no request is in flight.
//   Synchronous reset empties the queue and drops a request in flight;
//   cell contents are not cleared and are only read below the count.
// ----------------------------------------------------------------------------
module searchable_shift_fifo
    import ssf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    output logic       o_done,
    output t_rsp       o_rsp,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } t_state;

    t_state           r_state;
    logic [1:0]       r_func;
    t_rec             r_key;
    logic [CNT_W-1:0] r_count;
    logic [3:0]       r_cap;
    logic             r_ok;
    t_rec             r_pop_rec;
    logic             r_done;
    t_rsp             r_rsp;

    logic             accept;
    logic [CNT_W-1:0] eff_cap;
    logic             push_ok;
    logic             pop_ok;
    logic             full_now;
    logic             found;
    logic [POS_W-1:0] pos;
    logic             is_search;
    t_rsp             n_rsp;

    t_rec             cell_rec   [DEPTH];
    t_rec             cell_next  [DEPTH];
    logic [DEPTH-1:0] cell_match;
    t_cell_ctrl       cell_ctrl  [DEPTH];

    assign accept  = start && !busy;
    assign busy    = (r_state == ST_EXEC);
    assign eff_cap = (r_cap > 4'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(r_cap);
    assign push_ok = (r_func == FUNC_PUSH) && (r_count < eff_cap);
    assign pop_ok  = (r_func == FUNC_POP) && (r_count != '0);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == DEPTH - 1) begin : g_last
            assign cell_next[g] = '0;
        end else begin : g_mid
            assign cell_next[g] = cell_rec[g+1];
        end

        always_comb begin
            cell_ctrl[g].shift    = (r_state == ST_EXEC) && pop_ok;
            cell_ctrl[g].load_new = (r_state == ST_EXEC) && push_ok &&
                                    (r_count == CNT_W'(g));
            cell_ctrl[g].cmp      = (r_state == ST_EXEC);
        end

        ssf_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (cell_ctrl[g]),
            .i_new_rec  (r_key),
            .i_next_rec (cell_next[g]),
            .i_key      (r_key),
            .o_rec      (cell_rec[g]),
            .o_match    (cell_match[g])
        );
    end

    ssf_first_match u_first_match (
        .i_match (cell_match),
        .i_count (r_count),
        .o_found (found),
        .o_pos   (pos)
    );

    assign is_search = (r_func == FUNC_SEARCH);
    assign full_now  = (r_count >= eff_cap);

    always_comb begin
        n_rsp           = '0;
        n_rsp.ok        = r_ok;
        n_rsp.found     = is_search && found;
        n_rsp.position  = (is_search && found) ? 3'(pos) : 3'd0;
        n_rsp.out_word0 = r_pop_rec.w0;
        n_rsp.out_word1 = r_pop_rec.w1;
        n_rsp.out_word2 = r_pop_rec.w2;
        n_rsp.out_word3 = r_pop_rec.w3;
        n_rsp.out_age   = r_pop_rec.age;
        n_rsp.count     = 4'(r_count);
        n_rsp.empty_res = (r_count == '0);
        n_rsp.full_res  = full_now;
    end

    // request word and popped record, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_req.func;
            r_key  <= make_rec(i_req);
        end
        if (r_state == ST_EXEC) begin
            r_pop_rec <= pop_ok ? cell_rec[0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 4'(DEPTH);
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ok    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_ok <= push_ok || pop_ok || is_search;
                    if (push_ok) begin
                        r_count <= r_count + 1'b1;
                    end else if (pop_ok) begin
                        r_count <= r_count - 1'b1;
                    end
                    r_state <= ST_RESP;
                end
                ST_RESP: begin
                    r_rsp   <= n_rsp;
                    r_done  <= 1'b1;
                    r_state <= accept ? ST_EXEC : ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ----- hdl/ssf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_checker: port-level checks for the searchable shift FIFO
// Response timing and consistency of the status fields.
// ----------------------------------------------------------------------------
module ssf_checker
    import ssf_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input t_rsp       o_rsp
);

    // every accepted word is answered by a pulse on o_done
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##3 o_done)
        else $error("response missing after accept");

    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.empty_res == (o_rsp.count == 4'd0)) &&
                   (o_rsp.count <= 4'(DEPTH)))
        else $error("count and empty flag disagree");

    // no record comes out of a failed op or a search hit, and a hit needs ok
    a_zero_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (!o_rsp.ok || o_rsp.found) |->
            (o_rsp.out_word0 == 64'd0) && (o_rsp.out_age == 8'd0) && o_rsp.ok == 1'b1 ||
            (!o_rsp.ok && !o_rsp.found && o_rsp.out_word0 == 64'd0 &&
             o_rsp.out_age == 8'd0))
        else $error("record fields set on failed op or search");

endmodule

bind searchable_shift_fifo ssf_checker u_ssf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
